// ===== src/srsl_pkg.sv =====
// shared types, constants and helpers for the signed revision set lookup
// no dependencies

package srsl_pkg;

  localparam int DEF_MAX_ENTRIES = 16;
  localparam int ID_W            = 17;
  localparam int COUNT_W         = 5;
  localparam int STATUS_W        = 2;

  localparam logic [1:0] KIND_QUERY  = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNCHANGED = 2'd2;

  // smallest-magnitude search starts here
  localparam logic signed [ID_W-1:0] SMALL_INIT = 17'sd65535;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_APPEND = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  function automatic logic [ID_W-1:0] rev_mag(input logic signed [ID_W-1:0] v);
    logic [ID_W:0] w;
    w = {v[ID_W-1], v};
    rev_mag = v[ID_W-1] ? ID_W'((ID_W+1)'(0) - w) : ID_W'(w);
  endfunction

  // true when a equals the negation of b
  function automatic logic rev_negates(input logic signed [ID_W-1:0] a,
                                       input logic signed [ID_W-1:0] b);
    logic [ID_W:0] s;
    s = {a[ID_W-1], a} + {b[ID_W-1], b};
    rev_negates = (s == '0);
  endfunction

endpackage

// ===== src/srsl_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module srsl_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/signed_revision_set_lookup.sv =====
// Ordered list of signed revision ids held in one ram, with add, remove, clear and
// query operations. One word is worked at a time: a query or add walks the list
// through the ram read port at one entry per cycle, a removal or sign flip then
// closes the gap with a read-and-write-back sweep over the entries behind the hit,
// and the accept, append and output steps take their own states (S_IDLE, S_APPEND,
// S_DONE). A result word waits in S_DONE while the previous result word is held by
// result_stall. Depends on srsl_pkg and srsl_ram.

module signed_revision_set_lookup
  import srsl_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [1:0]                 kind,
  input  logic signed [ID_W-1:0]     rev_id,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [ID_W-1:0]     answer_rev,
  output logic                       before_first_hidden,
  output logic                       visible,
  output logic [STATUS_W-1:0]        status,
  output logic [COUNT_W-1:0]         entry_count
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  state_t state;

  logic [CW-1:0]            count;
  logic [CW-1:0]            rptr;
  logic [CW-1:0]            chk_pos;
  logic                     chk_vld;

  logic [1:0]               op;
  logic signed [ID_W-1:0]   id;
  logic [ID_W-1:0]          qmag;
  logic signed [ID_W-1:0]   best;
  logic signed [ID_W-1:0]   least;
  logic signed [ID_W-1:0]   match;
  logic                     found;
  logic [STATUS_W-1:0]      st;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [ID_W-1:0]   wr_data;
  logic signed [ID_W-1:0]   rd_data;
  logic [ID_W-1:0]          rd_mag;

  logic signed [ID_W-1:0]   q_answer;
  logic                     q_hidden;

  srsl_ram #(
    .WIDTH(ID_W),
    .DEPTH(MAX_ENTRIES)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rptr[AW-1:0]),
    .rd_data(rd_data)
  );

  assign item_stall = (state != S_IDLE);
  assign rd_mag     = rev_mag(rd_data);

  // shift writes entry back one place; append writes new id at the tail
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = id;
    if (state == S_SHIFT && chk_vld) begin
      wr_en   = 1'b1;
      wr_addr = AW'(chk_pos - CW'(1));
      wr_data = rd_data;
    end else if (state == S_APPEND) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    q_hidden = 1'b0;
    if (found) begin
      q_answer = match;
    end else if (best == '0) begin
      q_answer = '0;
      q_hidden = ~least[ID_W-1];
    end else begin
      q_answer = best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      chk_vld      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            op      <= kind;
            id      <= rev_id;
            qmag    <= rev_mag(rev_id);
            best    <= '0;
            least   <= SMALL_INIT;
            found   <= 1'b0;
            st      <= ST_DONE;
            rptr    <= '0;
            chk_vld <= 1'b0;
            if (kind == KIND_CLEAR) begin
              count <= '0;
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rptr < count) begin
            chk_vld <= 1'b1;
            chk_pos <= rptr;
            rptr    <= rptr + CW'(1);
          end else begin
            chk_vld <= 1'b0;
          end
          if (chk_vld) begin
            case (op)
              KIND_QUERY: begin
                if (rd_mag == qmag) begin
                  match <= rd_data;
                  found <= 1'b1;
                  state <= S_DONE;
                end else begin
                  if (rd_mag < rev_mag(least)) begin
                    least <= rd_data;
                  end
                  if (rd_mag < qmag && rd_mag > rev_mag(best)) begin
                    best <= rd_data;
                  end
                end
              end
              KIND_ADD: begin
                if (rev_negates(id, rd_data)) begin
                  rptr    <= chk_pos + CW'(1);
                  chk_vld <= 1'b0;
                  state   <= S_SHIFT;
                end else if (id == rd_data) begin
                  st    <= ST_UNCHANGED;
                  state <= S_DONE;
                end
              end
              default: begin
                if (id == rd_data) begin
                  rptr    <= chk_pos + CW'(1);
                  chk_vld <= 1'b0;
                  state   <= S_SHIFT;
                end
              end
            endcase
          end else if (rptr >= count) begin
            case (op)
              KIND_QUERY: begin
                state <= S_DONE;
              end
              KIND_ADD: begin
                if (count == CW'(MAX_ENTRIES)) begin
                  st    <= ST_FULL;
                  state <= S_DONE;
                end else begin
                  state <= S_APPEND;
                end
              end
              default: begin
                st    <= ST_UNCHANGED;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SHIFT: begin
          if (rptr < count) begin
            chk_vld <= 1'b1;
            chk_pos <= rptr;
            rptr    <= rptr + CW'(1);
          end else begin
            chk_vld <= 1'b0;
          end
          if (!chk_vld && rptr >= count) begin
            count <= count - CW'(1);
            state <= (op == KIND_ADD) ? S_APPEND : S_DONE;
          end
        end
        S_APPEND: begin
          count <= count + CW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!result_valid || !result_stall)) begin
      status      <= st;
      entry_count <= COUNT_W'(count);
      if (op == KIND_QUERY) begin
        answer_rev          <= q_answer;
        before_first_hidden <= q_hidden;
        visible             <= ~q_answer[ID_W-1] & ~q_hidden;
      end else begin
        answer_rev          <= '0;
        before_first_hidden <= 1'b0;
        visible             <= 1'b0;
      end
    end
  end

endmodule
